// File: hdl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the integer-to-decimal text unit
// Widths, character codes, cell control bundle and controller states.
// ----------------------------------------------------------------------------
package s2d_pkg;

	localparam int VALUE_W   = 32;
	localparam int CHAR_W    = 8;
	localparam int DIGIT_W   = 4;
	localparam int NUM_CELLS = 10;   // decimal digits of a 32-bit magnitude
	localparam int BCNT_W    = 5;    // counts the 32 magnitude bits
	localparam int DCNT_W    = 4;    // counts up to NUM_CELLS digits

	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
	localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

	// Control broadcast to every cell of the digit chain.
	typedef struct packed {
		logic clear;    // zero all digits
		logic convert;  // one shift-and-add-3 step
		logic shift;    // move digits one place toward the top
	} cell_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SIGN = 5'b00100,
		ST_SKIP = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

// File: hdl/s2d_cell.sv
// ----------------------------------------------------------------------------
// s2d_cell: one decimal digit of the conversion chain
// Holds a BCD digit; does the add-3-and-shift step or a plain digit shift.
// ----------------------------------------------------------------------------
module s2d_cell import s2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic               bit_in,
	output logic               bit_out,
	input  logic [DIGIT_W-1:0] dig_in,
	output logic [DIGIT_W-1:0] dig_out
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// Digits of five and above get +3 so the shift carries into the next cell.
	assign adj     = (digit_q >= DIGIT_FIVE) ? digit_q + DIGIT_ADJ : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign dig_out = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.convert) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= dig_in;
		end
	end

endmodule

// File: hdl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed 32-bit integer to decimal ASCII
// Sign handling, a row of ten BCD digit cells and a small output sequencer.
// ----------------------------------------------------------------------------
// Usage: pulse start with value while busy is low. The unit then sends the
// decimal text one character per strobe, most significant first: '-' for a
// negative value, then the digits without leading zeros ("0" for zero); the
// last character carries last = 1. The receiver cannot stall, so take every
// strobe. Busy stays high for the same time on every item, whatever its sign:
// shift-and-add-3 through the digit cells (one magnitude bit per cycle),
// a sign step, then a phase in which leading zero digits are shifted out and
// the remaining digits are shifted out as characters. The
// last character is on the ports in the first cycle with busy low, and a new
// start can be taken at the edge that ends that cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit import s2d_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [VALUE_W-1:0] value,
	output logic                     busy,
	output logic                     strobe,
	output logic [CHAR_W-1:0]        char_code,
	output logic                     last
);

	state_t              state_q;
	logic [VALUE_W-1:0]  mag_q;      // magnitude, shifted out MSB first
	logic                neg_q;
	logic [BCNT_W-1:0]   bit_cnt_q;
	logic [DCNT_W-1:0]   dig_cnt_q;  // digits still held in the chain
	logic                strobe_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	logic                accept;
	logic [VALUE_W-1:0]  bits_in;
	cell_ctrl_t          ctrl;
	logic [NUM_CELLS-1:0] carry;
	logic [DIGIT_W-1:0]  digit [NUM_CELLS];
	logic [DIGIT_W-1:0]  top_digit;
	logic                top_zero;
	logic                one_left;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign bits_in   = value;
	assign top_digit = digit[NUM_CELLS-1];
	assign top_zero  = (top_digit == '0);
	assign one_left  = (dig_cnt_q == DCNT_W'(1));

	// Cell control: clear on accept, convert while bits remain, shift while
	// skipping leading zeros or emitting digits.
	always_comb begin
		ctrl.clear   = accept;
		ctrl.convert = (state_q == ST_CONV);
		ctrl.shift   = (state_q == ST_EMIT) ||
		               ((state_q == ST_SKIP) && top_zero && !one_left);
	end

	// Digit chain: bit carries go up from cell 0, digits also move up on shift.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic               c_in;
		logic [DIGIT_W-1:0] d_in;
		if (i == 0) begin : g_first
			assign c_in = mag_q[VALUE_W-1];
			assign d_in = '0;
		end else begin : g_next
			assign c_in = carry[i-1];
			assign d_in = digit[i-1];
		end
		s2d_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.bit_in  (c_in),
			.bit_out (carry[i]),
			.dig_in  (d_in),
			.dig_out (digit[i])
		);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= bits_in[VALUE_W-1];
						bit_cnt_q <= BCNT_W'(VALUE_W - 1);
						dig_cnt_q <= DCNT_W'(NUM_CELLS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					strobe_q <= neg_q;
					state_q  <= ST_SKIP;
				end
				ST_SKIP: begin
					if (top_zero && !one_left) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q  <= 1'b1;
					dig_cnt_q <= dig_cnt_q - 1'b1;
					if (one_left) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: magnitude shift register and output character register.
	always_ff @(posedge clk) begin
		if (accept) begin
			// Unsigned negate: the most negative value maps to 2^31 cleanly.
			mag_q <= bits_in[VALUE_W-1] ? (~bits_in + 1'b1) : bits_in;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
		if (state_q == ST_SIGN) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == ST_EMIT) begin
			char_q <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
			last_q <= one_left;
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

// File: hdl/s2d_checker.sv
// ----------------------------------------------------------------------------
// s2d_checker: port-level checks for the integer-to-decimal text unit
// Character range, sign placement and busy behavior around each item.
// ----------------------------------------------------------------------------
module s2d_checker import s2d_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic signed [VALUE_W-1:0] value,
	input logic                      busy,
	input logic                      strobe,
	input logic [CHAR_W-1:0]         char_code,
	input logic                      last
);

	// Every character is '-' or a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == CHAR_MINUS) ||
		           (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 8'd9))
		else $error("character out of range");

	// A minus sign never ends the text.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (char_code == CHAR_MINUS) |-> !last)
		else $error("minus sign marked last");

	// Characters before the last come only while the item is in flight.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("character outside an item");

	// An accepted item raises busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start");

	// The last character is never directly followed by another.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("character right after last");

endmodule

bind signed_int_to_decimal_ascii_unit s2d_checker u_s2d_checker (.*);

// File: dv/signed_int_to_decimal_ascii_unit_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb: self-checking bench for the itoa unit
// Sends signed 32-bit items and checks every character strobe, in order,
// against a model of the decimal text. A short directed table is sent first:
// zero, unit values, both extremes, powers of ten and alternating bit
// patterns. A random mix of wide, small and power-of-ten values follows.
// The sender idles at random and pauses once until all text has drained.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;
	import s2d_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 350;
	localparam int MAX_GAP       = 10;
	localparam int PAUSE_AT      = 170;     // random item where the sender drains
	localparam int DRAIN_CYCLES  = 60;      // longer than one item's busy time
	localparam int CYCLE_LIMIT   = 200000;  // about 10x the slowest correct run
	localparam logic [VALUE_W-1:0] DECIMAL_RADIX = 10;

	// one character of expected text
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              is_last;
	} text_char_t;

	// directed row: txt empty means "ask the predictor"
	typedef struct {
		logic signed [VALUE_W-1:0] val;
		string                     txt;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic signed [VALUE_W-1:0]  value;
	logic                       busy;
	logic                       strobe;
	logic [CHAR_W-1:0]          char_code;
	logic                       last;

	text_char_t pending_chars[$];   // characters owed by the unit, oldest first
	int         error_count;
	int         cycle_count;

	signed_int_to_decimal_ascii_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Decimal text of one item. With txt given, the text is taken as typed;
	// otherwise it is built from the magnitude, digit by digit, lsd first.
	// The magnitude is formed unsigned, so the most negative value is fine.
	task automatic queue_decimal_text(input logic signed [VALUE_W-1:0] v,
			input string txt);
		logic [VALUE_W-1:0] mag;
		logic [DIGIT_W-1:0] digs[NUM_CELLS];
		int                 nd;
		bit                 neg;
		if (txt.len() != 0) begin
			for (int k = 0; k < txt.len(); k++)
				pending_chars.push_back('{code: txt[k], is_last: k == txt.len() - 1});
		end else begin
			neg = v[VALUE_W-1];
			mag = neg ? (0 - v) : v;
			nd  = 0;
			do begin
				digs[nd] = DIGIT_W'(mag % DECIMAL_RADIX);
				mag      = mag / DECIMAL_RADIX;
				nd++;
			end while (mag != 0 && nd < NUM_CELLS);
			if (neg)
				pending_chars.push_back('{code: CHAR_MINUS, is_last: 1'b0});
			for (int k = nd - 1; k >= 0; k--)
				pending_chars.push_back('{code: CHAR_ZERO + digs[k], is_last: k == 0});
		end
	endtask

	// Hand one item over: idle for gap cycles, then hold start until an edge
	// sees busy low. start is left high so a gap-free next item follows on.
	task automatic send_item(input logic signed [VALUE_W-1:0] v, input string txt,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		queue_decimal_text(v, txt);
	endtask

	// Random values: wide, small, around powers of ten, and the extremes.
	function automatic logic signed [VALUE_W-1:0] rand_value();
		logic signed [VALUE_W-1:0] v;
		logic [VALUE_W-1:0]        p;
		int                        sel;
		sel = $urandom_range(0, 9);
		if (sel <= 3) begin
			v = $urandom;
		end else if (sel <= 5) begin
			v = $urandom_range(0, 999);
		end else if (sel <= 7) begin
			p = 1;
			repeat ($urandom_range(0, 9)) p = p * DECIMAL_RADIX;
			v = p + $urandom_range(0, 2) - 1;
		end else if (sel == 8) begin
			v = $urandom_range(0, 99999);
		end else begin
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'h8000_0000;
				default: v = -1;
			endcase
		end
		// flip the sign of the small, five-digit and power-of-ten picks half the time
		if (sel != 9 && sel > 3 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Result side: the unit cannot be stalled, so every strobe is a character.
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
					char_code, last));
			end else begin
				exp_c = pending_chars.pop_front();
				if (char_code !== exp_c.code)
					report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
						char_code, exp_c.code));
				if (last !== exp_c.is_last)
					report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
						last, exp_c.is_last, exp_c.code));
			end
		end
	end

	// Watchdog: a hung handshake or a missing character ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		dir_row_t dir_tab[18];
		int       gap;

		// expected text typed in for the rows that read off at a glance
		dir_tab = '{
			'{32'sd0,          "0"},
			'{32'sd1,          "1"},
			'{-32'sd1,         "-1"},
			'{32'h7FFF_FFFF,   "2147483647"},
			'{32'h8000_0000,   "-2147483648"},
			'{32'h8000_0001,   "-2147483647"},
			'{32'sd9,          ""},
			'{32'sd10,         ""},
			'{-32'sd10,        ""},
			'{32'sd99,         ""},
			'{32'sd100,        ""},
			'{32'sd999999999,  ""},
			'{32'sd1000000000, "1000000000"},
			'{-32'sd1000000000, ""},
			'{32'h5555_5555,   ""},
			'{32'hAAAA_AAAA,   ""},
			'{32'sd12345,      ""},
			'{-32'sd98765,     ""}
		};

		clk         = 1'b0;
		error_count = 0;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		value      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table: first eight rows back to back, the rest with random gaps
		for (int i = 0; i < $size(dir_tab); i++)
			send_item(dir_tab[i].val, dir_tab[i].txt,
				(i < 8) ? 0 : $urandom_range(0, MAX_GAP));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == PAUSE_AT) begin
				// hold off until the unit has sent every owed character
				start <= 1'b0;
				@(posedge clk);
				while (pending_chars.size() != 0) @(posedge clk);
			end
			// every third run of 40 items goes without idling
			gap = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
			send_item(rand_value(), "", gap);
		end
		start <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/s2d_pkg.sv
hdl/s2d_cell.sv
hdl/signed_int_to_decimal_ascii_unit.sv
hdl/s2d_checker.sv
dv/signed_int_to_decimal_ascii_unit_tb.sv
